>>> design/cmf_pkg.sv
package cmf_pkg;

  // Field and arithmetic widths.
  localparam int DATA_W    = 16;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int FRAC_W    = 8;
  localparam int SPAN_W    = 16;
  localparam int NUM_W     = DATA_W + FRAC_W;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Sliding window geometry. The two middle ranks coincide for an odd length.
  localparam int WIN_LEN = 5;
  localparam int RANK_W  = $clog2(WIN_LEN);
  localparam int LO_RANK = (WIN_LEN - 1) / 2;
  localparam int HI_RANK = WIN_LEN / 2;

  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [SPAN_W-1:0]        span_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Configuration register map.
  localparam cfg_idx_t REG_OFFSET_X = cfg_idx_t'(0);
  localparam cfg_idx_t REG_OFFSET_Y = cfg_idx_t'(1);
  localparam cfg_idx_t REG_OFFSET_Z = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPAN_X   = cfg_idx_t'(3);
  localparam cfg_idx_t REG_SPAN_Y   = cfg_idx_t'(4);
  localparam cfg_idx_t REG_SPAN_Z   = cfg_idx_t'(5);

  localparam span_t   SPAN_RESET = span_t'(256);
  localparam sample_t SAT_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam sample_t SAT_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

  // Top-level sequencing states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

endpackage

>>> design/cmf_if.sv
// Input channel: one raw three-axis sample per beat.
interface cmf_in_if;
  logic                  valid;
  logic                  ready;
  cmf_pkg::sample_t      raw_x;
  cmf_pkg::sample_t      raw_y;
  cmf_pkg::sample_t      raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

// Result channel: one set of three medians per beat.
interface cmf_out_if;
  logic                  valid;
  logic                  ready;
  cmf_pkg::sample_t      median_x;
  cmf_pkg::sample_t      median_y;
  cmf_pkg::sample_t      median_z;

  modport source (output valid, output median_x, output median_y, output median_z,
                  input ready);
  modport sink   (input valid, input median_x, input median_y, input median_z,
                  output ready);
endinterface

// Configuration write channel: register index and data per beat.
interface cmf_cfg_if;
  logic                        valid;
  logic                        ready;
  cmf_pkg::cfg_idx_t           index;
  logic [cmf_pkg::DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/cmf_div.sv
// Signed Q8.8 correction divider: (diff * 256) / span, truncated toward
// zero and saturated to 16 bits signed. Restoring division on the
// magnitude, two quotient bits per cycle.
module cmf_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [cmf_pkg::DIFF_W-1:0]    diff,
  input  cmf_pkg::span_t                       span,
  output logic                                 done,
  output cmf_pkg::sample_t                     quot
);

  localparam logic [cmf_pkg::NUM_W-1:0] NEG_LIM =
    {{(cmf_pkg::NUM_W-cmf_pkg::DATA_W){1'b0}}, 1'b1, {(cmf_pkg::DATA_W-1){1'b0}}};
  localparam logic [cmf_pkg::NUM_W-1:0] POS_LIM = NEG_LIM - 1'b1;

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [cmf_pkg::SPAN_W:0] div_step(
    input logic [cmf_pkg::SPAN_W-1:0] rem,
    input logic                       nb,
    input cmf_pkg::span_t             dv
  );
    logic [cmf_pkg::SPAN_W:0] trial;
    logic [cmf_pkg::SPAN_W:0] sub;
    trial = {rem, nb};
    sub   = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      return {1'b1, sub[cmf_pkg::SPAN_W-1:0]};
    end
    return {1'b0, trial[cmf_pkg::SPAN_W-1:0]};
  endfunction

  logic                          busy_r;
  logic                          fin_r;
  logic                          done_r;
  logic [cmf_pkg::STEP_W-1:0]    cnt_r;
  logic [cmf_pkg::SPAN_W-1:0]    rem_r;
  logic [cmf_pkg::NUM_W-1:0]     num_r;
  cmf_pkg::span_t                span_r;
  logic                          neg_r;
  logic                          zero_r;
  cmf_pkg::sample_t              quot_r;

  logic [cmf_pkg::DIFF_W-1:0]    mag;
  logic [cmf_pkg::SPAN_W:0]      s1;
  logic [cmf_pkg::SPAN_W:0]      s2;
  logic [cmf_pkg::NUM_W-1:0]     neg_q;
  cmf_pkg::sample_t              sat_q;

  // Magnitude of the incoming difference; it always fits in 16 bits.
  assign mag = diff[cmf_pkg::DIFF_W-1] ? (cmf_pkg::DIFF_W'(0) - diff) : diff;

  // Two chained restoring steps per cycle.
  assign s1 = div_step(rem_r, num_r[cmf_pkg::NUM_W-1], span_r);
  assign s2 = div_step(s1[cmf_pkg::SPAN_W-1:0], num_r[cmf_pkg::NUM_W-2], span_r);

  // Sign and saturation of the finished quotient held in num_r.
  assign neg_q = cmf_pkg::NUM_W'(0) - num_r;
  always_comb begin
    if (zero_r) begin
      sat_q = '0;
    end else if (neg_r) begin
      sat_q = (num_r > NEG_LIM) ? cmf_pkg::SAT_MIN : neg_q[cmf_pkg::DATA_W-1:0];
    end else begin
      sat_q = (num_r > POS_LIM) ? cmf_pkg::SAT_MAX : num_r[cmf_pkg::DATA_W-1:0];
    end
  end

  // Control sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r  <= 1'b0;
      done_r <= fin_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmf_pkg::STEP_W'(cmf_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the low end of num_r.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      num_r  <= {mag[cmf_pkg::DATA_W-1:0], {cmf_pkg::FRAC_W{1'b0}}};
      span_r <= span;
      neg_r  <= diff[cmf_pkg::DIFF_W-1];
      zero_r <= (diff == '0);
    end else if (busy_r) begin
      rem_r <= s2[cmf_pkg::SPAN_W-1:0];
      num_r <= {num_r[cmf_pkg::NUM_W-3:0], s1[cmf_pkg::SPAN_W], s2[cmf_pkg::SPAN_W]};
    end
    if (fin_r) begin
      quot_r <= sat_q;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> design/cmf_lane.sv
// One axis lane: offset subtract, divide, window shift, rank and pick
// the median.
module cmf_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  cmf_pkg::sample_t     raw,
  input  cmf_pkg::sample_t     offset,
  input  cmf_pkg::span_t       span,
  output logic                 done,
  output cmf_pkg::sample_t     median
);

  logic signed [cmf_pkg::DIFF_W-1:0] diff;
  logic                              div_done;
  cmf_pkg::sample_t                  div_quot;

  cmf_pkg::sample_t                  win_r  [cmf_pkg::WIN_LEN];
  logic [cmf_pkg::RANK_W-1:0]        rank_c [cmf_pkg::WIN_LEN];
  logic [cmf_pkg::RANK_W-1:0]        rank_r [cmf_pkg::WIN_LEN];
  logic                              rank_go_r;
  logic                              pick_go_r;
  logic                              done_r;
  cmf_pkg::sample_t                  med_r;

  cmf_pkg::sample_t                  lo_val;
  cmf_pkg::sample_t                  hi_val;
  logic signed [cmf_pkg::DIFF_W-1:0] mid_sum;

  // Exact 17-bit difference.
  assign diff = {raw[cmf_pkg::DATA_W-1], raw} - {offset[cmf_pkg::DATA_W-1], offset};

  cmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .diff  (diff),
    .span  (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  // The newest value enters at the front and the oldest drops out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cmf_pkg::WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (div_done) begin
      win_r[0] <= div_quot;
      for (int i = 1; i < cmf_pkg::WIN_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // Sorted position of each entry; ties are broken by entry position, so
  // the ranks form a permutation.
  always_comb begin
    for (int i = 0; i < cmf_pkg::WIN_LEN; i++) begin
      rank_c[i] = '0;
      for (int j = 0; j < cmf_pkg::WIN_LEN; j++) begin
        if ((j != i) && ((win_r[j] < win_r[i]) || ((win_r[j] == win_r[i]) && (j < i)))) begin
          rank_c[i] = rank_c[i] + cmf_pkg::RANK_W'(1);
        end
      end
    end
  end

  // Pick the two middle entries and take the floor of their mean.
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < cmf_pkg::WIN_LEN; i++) begin
      if (rank_r[i] == cmf_pkg::RANK_W'(cmf_pkg::LO_RANK)) begin
        lo_val = win_r[i];
      end
      if (rank_r[i] == cmf_pkg::RANK_W'(cmf_pkg::HI_RANK)) begin
        hi_val = win_r[i];
      end
    end
  end
  assign mid_sum = {lo_val[cmf_pkg::DATA_W-1], lo_val} + {hi_val[cmf_pkg::DATA_W-1], hi_val};

  // Stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_go_r <= 1'b0;
      pick_go_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      rank_go_r <= div_done;
      pick_go_r <= rank_go_r;
      done_r    <= pick_go_r;
    end
  end

  // Rank and median registers.
  always_ff @(posedge clk) begin
    if (rank_go_r) begin
      for (int i = 0; i < cmf_pkg::WIN_LEN; i++) begin
        rank_r[i] <= rank_c[i];
      end
    end
    if (pick_go_r) begin
      med_r <= mid_sum[cmf_pkg::DIFF_W-1:1];
    end
  end

  assign done   = done_r;
  assign median = med_r;

endmodule

>>> design/calibrated_median5_filter.sv
// Channel  Dir  Fields                          Beat taken when
// in_ch    in   raw_x, raw_y, raw_z             in_ch.valid && in_ch.ready
// out_ch   out  median_x, median_y, median_z    out_ch.valid && out_ch.ready
// cfg_ch   in   index, data                     cfg_ch.valid && cfg_ch.ready
//
// An input beat passes from acceptance to a loaded result through the
// per-axis divider (two quotient bits a cycle over 24 bits), then
// saturation, window shift, ranking, median pick and the output load, each
// registered. The next input is taken the cycle after that load; a stalled
// output that is still full when the lanes finish holds the new result, and
// the input, until it drains.
// Reset is synchronous and active low; it clears the windows to zero and
// loads offsets of 0 and spans of unity. Configuration is always ready.
module calibrated_median5_filter (
  input  logic       clk,
  input  logic       rst_n,
  cmf_in_if.sink     in_ch,
  cmf_out_if.source  out_ch,
  cmf_cfg_if.sink    cfg_ch
);

  cmf_pkg::state_t   state_r;
  cmf_pkg::state_t   state_nxt;

  cmf_pkg::sample_t  off_r    [cmf_pkg::NUM_AXES];
  cmf_pkg::span_t    span_r   [cmf_pkg::NUM_AXES];
  cmf_pkg::sample_t  raw_a    [cmf_pkg::NUM_AXES];
  cmf_pkg::sample_t  lane_med [cmf_pkg::NUM_AXES];
  cmf_pkg::sample_t  med_out_r[cmf_pkg::NUM_AXES];
  logic [cmf_pkg::NUM_AXES-1:0] lane_done;

  logic in_fire;
  logic cfg_fire;
  logic out_free;
  logic load;
  logic out_valid_r;
  logic out_valid_nxt;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == cmf_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign raw_a[0] = in_ch.raw_x;
  assign raw_a[1] = in_ch.raw_y;
  assign raw_a[2] = in_ch.raw_z;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < cmf_pkg::NUM_AXES; a++) begin
        off_r[a]  <= '0;
        span_r[a] <= cmf_pkg::SPAN_RESET;
      end
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        cmf_pkg::REG_OFFSET_X: off_r[0]  <= cfg_ch.data;
        cmf_pkg::REG_OFFSET_Y: off_r[1]  <= cfg_ch.data;
        cmf_pkg::REG_OFFSET_Z: off_r[2]  <= cfg_ch.data;
        cmf_pkg::REG_SPAN_X:   span_r[0] <= cfg_ch.data;
        cmf_pkg::REG_SPAN_Y:   span_r[1] <= cfg_ch.data;
        cmf_pkg::REG_SPAN_Z:   span_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // One lane per axis, all started by the same input beat.
  for (genvar a = 0; a < cmf_pkg::NUM_AXES; a++) begin : g_lane
    cmf_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (in_fire),
      .raw    (raw_a[a]),
      .offset (off_r[a]),
      .span   (span_r[a]),
      .done   (lane_done[a]),
      .median (lane_med[a])
    );
  end

  // Sequencing: wait for the lanes, then merge their medians into the
  // output register as soon as it is free.
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    case (state_r)
      cmf_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = cmf_pkg::S_RUN;
        end
      end
      cmf_pkg::S_RUN: begin
        if (&lane_done) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = cmf_pkg::S_IDLE;
          end else begin
            state_nxt = cmf_pkg::S_HOLD;
          end
        end
      end
      cmf_pkg::S_HOLD: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = cmf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cmf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int a = 0; a < cmf_pkg::NUM_AXES; a++) begin
        med_out_r[a] <= lane_med[a];
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.median_x = med_out_r[0];
  assign out_ch.median_y = med_out_r[1];
  assign out_ch.median_z = med_out_r[2];

  // The lanes run in lockstep and finish together.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> (&lane_done))
    else $error("lanes finished out of step");

  // Lane results only arrive while a sample is in flight.
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> (state_r == cmf_pkg::S_RUN))
    else $error("lane result outside of a running sample");

  // An accepted sample always starts a run.
  a_fire_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == cmf_pkg::S_RUN) && !in_ch.ready)
    else $error("accepted sample did not start a run");

endmodule
